// ===== rtl/error_pixel_render_core_defines.svh =====
// Assertion macros for the error pixel render RTL.
`ifndef ERROR_PIXEL_RENDER_CORE_DEFINES_SVH
`define ERROR_PIXEL_RENDER_CORE_DEFINES_SVH

`ifndef SYNTH
// Check prop on every clock edge outside reset.
`define EPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that cons holds in the cycle after ante.
`define EPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EPR_ASSERT(lbl, prop, msg)
`define EPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/epr_pkg.sv =====
// Types, constants and helper functions of the error pixel render core.
`default_nettype none

package epr_pkg;

  typedef enum logic [2:0] {
    MODE_FLAT               = 3'd0,
    MODE_MOVEMENT           = 3'd1,
    MODE_FLAT_INTENSITY     = 3'd2,
    MODE_MOVEMENT_INTENSITY = 3'd3,
    MODE_DIFF_ONLY          = 3'd4
  } render_mode_e;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_RED   = 3'd1,
    CFG_GREEN = 3'd2,
    CFG_BLUE  = 3'd3,
    CFG_ALPHA = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] compare_red;
    logic [7:0] compare_green;
    logic [7:0] compare_blue;
    logic [7:0] compare_alpha;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_word_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } cfg_t;

  // color lanes
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // datapath widths
  localparam int SQD_W   = 16;             // squared channel difference
  localparam int D2_W    = 18;             // sum of three squares
  localparam int FRAC_W  = 16;             // radicand scale, 8 fraction bits of root
  localparam int RAD_W   = D2_W + FRAC_W;  // 34-bit radicand
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int TERM_W  = 26;             // c*65536 + ratio*(255-c)
  localparam int MIX_W   = TERM_W + 8;
  localparam int MV_W    = 17;             // m*(c+255)
  localparam int DIV_W   = 18;             // input of the divide-by-255 unit
  localparam int RATIO_W = 17;             // Q1.16 blend ratio

  // ratio = floor(root * 1024 / 1275) by reciprocal multiply and one correction
  localparam int RATIO_X_W   = ROOT_W + 10;
  localparam int RATIO_DIV   = 1275;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = RATIO_X_W + RECIP_W;
  localparam int QM_W        = RATIO_X_W + 1;
  localparam int RATIO_REM_W = 12;
  localparam logic [RECIP_W-1:0] RATIO_RECIP = RECIP_W'((64'd1 << RATIO_X_W) / RATIO_DIV);

  // square root pipeline
  localparam int SQRT_PAIRS  = RAD_W / 2;
  localparam int SQRT_STEPS  = 3;
  localparam int SQRT_STAGES = (SQRT_PAIRS + SQRT_STEPS - 1) / SQRT_STEPS;

  // pipeline stage indexes
  localparam int ST_SQD       = 0;
  localparam int ST_SUM       = 1;
  localparam int ST_ROOT0     = 2;
  localparam int ST_ROOT_LAST = ST_ROOT0 + SQRT_STAGES - 1;
  localparam int ST_PROD      = ST_ROOT_LAST + 1;
  localparam int ST_RATIO     = ST_PROD + 1;
  localparam int ST_TERM      = ST_RATIO + 1;
  localparam int ST_MIX       = ST_TERM + 1;
  localparam int ST_OUT       = ST_MIX + 1;
  localparam int NUM_STAGES   = ST_OUT + 1;

  localparam logic [DIV_W-1:0] DIV_SAT_LIMIT = DIV_W'(255 * 256);

  // floor(y / 255) saturated to 255; below the limit y / 256 is short by at most one
  function automatic logic [7:0] div255_sat(input logic [DIV_W-1:0] y);
    logic [7:0] q0;
    logic [8:0] rem;
    logic [7:0] res;
    q0  = y[15:8];
    rem = {1'b0, y[7:0]} + {1'b0, q0};
    if (y >= DIV_SAT_LIMIT) begin
      res = 8'hFF;
    end else if (rem >= 9'd255) begin
      res = q0 + 8'd1;
    end else begin
      res = q0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/epr_lane.sv =====
// One color lane: squared difference in front, blend products at the back.
`default_nettype none

module epr_lane import epr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [ST_MIX:0]      adv_i,
  input  wire logic [7:0]           base_i,
  input  wire logic [7:0]           cmp_i,
  input  wire logic [7:0]           mis_i,
  input  wire logic [RATIO_W-1:0]   ratio_i,
  output logic      [SQD_W-1:0]     sqd_o,
  output logic      [DIV_W-1:0]     blend_o,
  output logic      [MV_W-1:0]      move_o,
  output logic      [7:0]           cmp_o
);

  logic [7:0]         cmp_q [ST_MIX+1];
  logic [SQD_W-1:0]   sqd_q;
  logic [TERM_W-1:0]  term_q;
  logic [DIV_W-1:0]   blend_q;
  logic [MV_W-1:0]    move_q;

  logic [7:0]         diff;
  logic [TERM_W-1:0]  term_d;
  logic [MIX_W-1:0]   mix;
  logic [MV_W-1:0]    move_d;

  always_comb begin
    diff   = (base_i > cmp_i) ? (base_i - cmp_i) : (cmp_i - base_i);
    term_d = TERM_W'({cmp_q[ST_RATIO], 16'b0})
           + TERM_W'(ratio_i) * TERM_W'(8'd255 - cmp_q[ST_RATIO]);
    mix    = MIX_W'(mis_i) * MIX_W'(term_q);
    move_d = MV_W'(mis_i) * MV_W'({1'b0, cmp_q[ST_TERM]} + 9'd255);
  end

  // register the lane results and carry the compare channel alongside the pipeline
  always_ff @(posedge clk_i) begin
    if (adv_i[ST_SQD]) begin
      cmp_q[ST_SQD] <= cmp_i;
      sqd_q         <= SQD_W'(diff) * SQD_W'(diff);
    end
    for (int k = 1; k <= ST_MIX; k++) begin
      if (adv_i[k]) begin
        cmp_q[k] <= cmp_q[k-1];
      end
    end
    if (adv_i[ST_TERM]) begin
      term_q <= term_d;
    end
    if (adv_i[ST_MIX]) begin
      blend_q <= mix[MIX_W-1 -: DIV_W];
      move_q  <= move_d;
    end
  end

  assign sqd_o   = sqd_q;
  assign blend_o = blend_q;
  assign move_o  = move_q;
  assign cmp_o   = cmp_q[ST_MIX];

endmodule

`default_nettype wire

// ===== rtl/epr_sqrt.sv =====
// Distance unit: sums the lane squares and takes a pipelined integer square root.
`default_nettype none

module epr_sqrt import epr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic [ST_ROOT_LAST:ST_SUM]    adv_i,
  input  wire logic [NUM_CH-1:0][SQD_W-1:0]  sqd_i,
  output logic      [ROOT_W-1:0]             root_o
);

  logic [D2_W-1:0]   d2_q;
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];

  always_ff @(posedge clk_i) begin
    if (adv_i[ST_SUM]) begin
      d2_q <= D2_W'(sqd_i[CH_RED]) + D2_W'(sqd_i[CH_GREEN]) + D2_W'(sqd_i[CH_BLUE]);
    end
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in, rem_c;
    logic [ROOT_W-1:0] root_in, root_c;
    logic [RAD_W-1:0]  rad_in, rad_c;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {d2_q, {FRAC_W{1'b0}}};
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // restoring square root, one result bit per step
    always_comb begin
      logic [REM_W-1:0] trial;
      rem_c  = rem_in;
      root_c = root_in;
      rad_c  = rad_in;
      trial  = '0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (s * SQRT_STEPS + j < SQRT_PAIRS) begin
          rem_c = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
          rad_c = {rad_c[RAD_W-3:0], 2'b00};
          trial = {1'b0, root_c, 2'b01};
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[ROOT_W-2:0], 1'b1};
          end else begin
            root_c = {root_c[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[ST_ROOT0 + s]) begin
        rem_q[s]  <= rem_c;
        root_q[s] <= root_c;
        rad_q[s]  <= rad_c;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/epr_ratio.sv =====
// Blend ratio: root * 1024 / 1275 by reciprocal multiply and one correction step.
`default_nettype none

module epr_ratio import epr_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic [ST_RATIO:ST_PROD]   adv_i,
  input  wire logic [ROOT_W-1:0]         root_i,
  output logic      [RATIO_W-1:0]        ratio_o
);

  logic [ROOT_W-1:0]      root_q;
  logic [PROD_W-1:0]      prod_q;
  logic [RATIO_W-1:0]     ratio_q;

  logic [RATIO_X_W-1:0]   x_in;
  logic [RATIO_X_W-1:0]   x_q;
  logic [RATIO_W-1:0]     q0;
  logic [QM_W-1:0]        qm;
  logic [QM_W-1:0]        rem;
  logic [RATIO_W-1:0]     ratio_d;

  always_comb begin
    x_in    = {root_i, 10'b0};
    x_q     = {root_q, 10'b0};
    q0      = prod_q[PROD_W-1 -: RATIO_W];
    qm      = QM_W'(q0) * QM_W'(RATIO_DIV);
    rem     = {1'b0, x_q} - qm;
    // estimate is low by at most one
    ratio_d = (rem[RATIO_REM_W-1:0] >= RATIO_REM_W'(RATIO_DIV)) ? (q0 + 1'b1) : q0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[ST_PROD]) begin
      root_q <= root_i;
      prod_q <= PROD_W'(x_in) * PROD_W'(RATIO_RECIP);
    end
    if (adv_i[ST_RATIO]) begin
      ratio_q <= ratio_d;
    end
  end

  assign ratio_o = ratio_q;

endmodule

`default_nettype wire

// ===== rtl/epr_merge.sv =====
// Output stage: merges lane results by render mode into the registered result word.
`default_nettype none

module epr_merge import epr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire cfg_t                          cfg_i,
  input  wire logic [NUM_CH-1:0][DIV_W-1:0]  blend_i,
  input  wire logic [NUM_CH-1:0][MV_W-1:0]   move_i,
  input  wire logic [NUM_CH-1:0][7:0]        cmp_i,
  input  wire logic [7:0]                    cmp_alpha_i,
  input  wire logic [7:0]                    dist_alpha_i,
  output out_word_t                          out_o
);

  out_word_t out_d, out_q;

  always_comb begin
    out_d.out_red   = cfg_i.red;
    out_d.out_green = cfg_i.green;
    out_d.out_blue  = cfg_i.blue;
    out_d.out_alpha = cfg_i.alpha;
    case (cfg_i.mode)
      MODE_MOVEMENT: begin
        out_d.out_red   = div255_sat({2'b00, move_i[CH_RED][MV_W-1:1]});
        out_d.out_green = div255_sat({2'b00, move_i[CH_GREEN][MV_W-1:1]});
        out_d.out_blue  = div255_sat({2'b00, move_i[CH_BLUE][MV_W-1:1]});
        out_d.out_alpha = cmp_alpha_i;
      end
      MODE_FLAT_INTENSITY: begin
        out_d.out_alpha = dist_alpha_i;
      end
      MODE_MOVEMENT_INTENSITY: begin
        out_d.out_red   = div255_sat(blend_i[CH_RED]);
        out_d.out_green = div255_sat(blend_i[CH_GREEN]);
        out_d.out_blue  = div255_sat(blend_i[CH_BLUE]);
        out_d.out_alpha = cmp_alpha_i;
      end
      MODE_DIFF_ONLY: begin
        out_d.out_red   = cmp_i[CH_RED];
        out_d.out_green = cmp_i[CH_GREEN];
        out_d.out_blue  = cmp_i[CH_BLUE];
        out_d.out_alpha = cmp_alpha_i;
      end
      default: begin
        // flat, and the unused mode codes
        out_d.out_alpha = cfg_i.alpha;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/error_pixel_render_core.sv =====
// Top level of the error pixel render core.
`default_nettype none

`include "error_pixel_render_core_defines.svh"

// Error pixel render core. Takes one base/compare pixel word per cycle while
// not stalled and returns one rendered word per input, in order. Three color
// lanes compute squared differences and blend products side by side; the
// distance goes through a six-stage restoring square root (up to three result
// bits per stage), then a reciprocal multiply for the Q1.16 blend ratio, and
// a merge stage selects the result by render mode. Every stage holds its own
// valid bit, so a stall at the output only blocks the input once all 13
// stages are full.
// Configuration registers must be written while no word is in flight.
module error_pixel_render_core import epr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_word_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  cfg_t cfg_q;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] valid_in;
  logic [NUM_STAGES:0]   ready;

  logic [NUM_CH-1:0][7:0]       base_ch, cmp_ch, mis_ch;
  logic [NUM_CH-1:0][SQD_W-1:0] sqd;
  logic [NUM_CH-1:0][DIV_W-1:0] blend;
  logic [NUM_CH-1:0][MV_W-1:0]  move;
  logic [NUM_CH-1:0][7:0]       cmp_late;
  logic [ROOT_W-1:0]            root;
  logic [RATIO_W-1:0]           ratio;

  logic [7:0] alpha_q [ST_MIX+1];
  logic [7:0] dist_q  [ST_PROD:ST_MIX];
  logic [7:0] dist_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_FLAT;
      cfg_q.red   <= 8'hFF;
      cfg_q.green <= 8'h00;
      cfg_q.blue  <= 8'h00;
      cfg_q.alpha <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  cfg_q.mode  <= cfg_data_i[2:0];
        CFG_RED:   cfg_q.red   <= cfg_data_i;
        CFG_GREEN: cfg_q.green <= cfg_data_i;
        CFG_BLUE:  cfg_q.blue  <= cfg_data_i;
        CFG_ALPHA: cfg_q.alpha <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  assign ready[NUM_STAGES] = !out_stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  assign valid_in = {valid_q[NUM_STAGES-2:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      valid_d[k] = ready[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[ST_SQD];
  assign out_valid_o = valid_q[ST_OUT];

  assign base_ch[CH_RED]   = in_data_i.base_red;
  assign base_ch[CH_GREEN] = in_data_i.base_green;
  assign base_ch[CH_BLUE]  = in_data_i.base_blue;
  assign cmp_ch[CH_RED]    = in_data_i.compare_red;
  assign cmp_ch[CH_GREEN]  = in_data_i.compare_green;
  assign cmp_ch[CH_BLUE]   = in_data_i.compare_blue;
  assign mis_ch[CH_RED]    = cfg_q.red;
  assign mis_ch[CH_GREEN]  = cfg_q.green;
  assign mis_ch[CH_BLUE]   = cfg_q.blue;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    epr_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (ready[ST_MIX:0]),
      .base_i  (base_ch[c]),
      .cmp_i   (cmp_ch[c]),
      .mis_i   (mis_ch[c]),
      .ratio_i (ratio),
      .sqd_o   (sqd[c]),
      .blend_o (blend[c]),
      .move_o  (move[c]),
      .cmp_o   (cmp_late[c])
    );
  end

  epr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .adv_i  (ready[ST_ROOT_LAST:ST_SUM]),
    .sqd_i  (sqd),
    .root_o (root)
  );

  epr_ratio u_ratio (
    .clk_i   (clk_i),
    .adv_i   (ready[ST_RATIO:ST_PROD]),
    .root_i  (root),
    .ratio_o (ratio)
  );

  // integer distance, saturated to a byte
  assign dist_d = root[ROOT_W-1] ? 8'hFF : root[ROOT_W-2 -: 8];

  // carry compare alpha and distance alpha to the merge stage
  always_ff @(posedge clk_i) begin
    if (ready[ST_SQD]) begin
      alpha_q[ST_SQD] <= in_data_i.compare_alpha;
    end
    for (int k = 1; k <= ST_MIX; k++) begin
      if (ready[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
    if (ready[ST_PROD]) begin
      dist_q[ST_PROD] <= dist_d;
    end
    for (int k = ST_PROD + 1; k <= ST_MIX; k++) begin
      if (ready[k]) begin
        dist_q[k] <= dist_q[k-1];
      end
    end
  end

  epr_merge u_merge (
    .clk_i        (clk_i),
    .en_i         (ready[ST_OUT]),
    .cfg_i        (cfg_q),
    .blend_i      (blend),
    .move_i       (move),
    .cmp_i        (cmp_late),
    .cmp_alpha_i  (alpha_q[ST_MIX]),
    .dist_alpha_i (dist_q[ST_MIX]),
    .out_o        (out_data_o)
  );

  `EPR_ASSERT(a_stall_only_full, in_stall_o |-> (&valid_q),
              "input stalled with a free stage")
  `EPR_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, valid_q[ST_SQD],
                   "accepted word lost at entry")
  `EPR_ASSERT(a_flat_word, (out_valid_o && cfg_q.mode == MODE_FLAT) |->
              (out_data_o.out_red == cfg_q.red && out_data_o.out_alpha == cfg_q.alpha),
              "flat word differs from mismatch color")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the error pixel render core.
module tb import epr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT      = 500000;
  localparam int          DRAIN_CYCLES     = 24;
  localparam int          RANDOM_PHASES    = 16;
  localparam int          PIXELS_PER_PHASE = 85;
  localparam int          MAX_PRINTED      = 30;
  localparam logic [2:0]  CFG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  CFG_UNUSED_LAST  = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;
  typedef enum int {PIX_RANDOM, PIX_NEAR, PIX_EXTREME, PIX_SAME} pixel_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_word_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;

  error_pixel_render_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // mirror of the configuration registers
  logic [2:0] mode_q  = MODE_FLAT;
  logic [7:0] red_q   = 8'hFF;
  logic [7:0] green_q = 8'h00;
  logic [7:0] blue_q  = 8'h00;
  logic [7:0] alpha_q = 8'hFF;

  in_word_t   pixel_q[$];
  out_word_t  rgba_expect_q[$];
  int         sent_cnt = 0;
  int         acc_cnt = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         settings_cnt = 0;
  int         mode_hits[8];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [7:0] clip8(input longint unsigned v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic longint unsigned sq_gap(input logic [7:0] a, input logic [7:0] b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  // bitwise root search, result below 2^17 for any pixel pair
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [7:0] tint_avg(input logic [7:0] c, input logic [7:0] m);
    longint unsigned cl;
    longint unsigned ml;
    cl = c;
    ml = m;
    return clip8((cl * ml + 255 * ml) / 510);
  endfunction

  function automatic logic [7:0] shade_toward(input logic [7:0] c, input logic [7:0] m,
                                              input longint unsigned ratio);
    longint unsigned cl;
    longint unsigned ml;
    cl = c;
    ml = m;
    return clip8((ml * (cl * 65536 + ratio * (255 - cl))) / (65536 * 255));
  endfunction

  function automatic out_word_t render_pixel(input in_word_t px);
    longint unsigned dist_sq;
    longint unsigned root;
    longint unsigned ratio;
    out_word_t       o;
    dist_sq = sq_gap(px.base_red, px.compare_red) + sq_gap(px.base_green, px.compare_green)
            + sq_gap(px.base_blue, px.compare_blue);
    root  = root_floor(dist_sq << 16);
    ratio = (root * 262144) / 326400;
    case (mode_q)
      MODE_MOVEMENT: begin
        o.out_red   = tint_avg(px.compare_red, red_q);
        o.out_green = tint_avg(px.compare_green, green_q);
        o.out_blue  = tint_avg(px.compare_blue, blue_q);
        o.out_alpha = px.compare_alpha;
      end
      MODE_FLAT_INTENSITY: begin
        o = {red_q, green_q, blue_q, clip8(root >> 8)};
      end
      MODE_MOVEMENT_INTENSITY: begin
        o.out_red   = shade_toward(px.compare_red, red_q, ratio);
        o.out_green = shade_toward(px.compare_green, green_q, ratio);
        o.out_blue  = shade_toward(px.compare_blue, blue_q, ratio);
        o.out_alpha = px.compare_alpha;
      end
      MODE_DIFF_ONLY: begin
        o = {px.compare_red, px.compare_green, px.compare_blue, px.compare_alpha};
      end
      default: begin
        o = {red_q, green_q, blue_q, alpha_q};
      end
    endcase
    return o;
  endfunction

  function automatic logic [7:0] near_value(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic logic [7:0] pick_extreme();
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  function automatic in_word_t rand_pixel();
    in_word_t     p;
    pixel_style_e style;
    int           roll;
    roll = $urandom_range(0, 9);
    style = (roll < 4) ? PIX_RANDOM : (roll < 7) ? PIX_NEAR : (roll < 9) ? PIX_EXTREME : PIX_SAME;
    p = {$urandom, 24'($urandom)};
    case (style)
      PIX_NEAR: begin
        p.compare_red   = near_value(p.base_red);
        p.compare_green = near_value(p.base_green);
        p.compare_blue  = near_value(p.base_blue);
      end
      PIX_EXTREME: begin
        p.base_red      = pick_extreme();
        p.base_green    = pick_extreme();
        p.base_blue     = pick_extreme();
        p.compare_red   = pick_extreme();
        p.compare_green = pick_extreme();
        p.compare_blue  = pick_extreme();
      end
      PIX_SAME: begin
        p.compare_red   = p.base_red;
        p.compare_green = p.base_green;
        p.compare_blue  = p.base_blue;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_MODE:  mode_q  = val[2:0];
      CFG_RED:   red_q   = val;
      CFG_GREEN: green_q = val;
      CFG_BLUE:  blue_q  = val;
      CFG_ALPHA: alpha_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] mode_word, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_RED, r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_BLUE, b);
    write_reg(CFG_ALPHA, a);
    settings_cnt++;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || sent_cnt != acc_cnt || rgba_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // sender: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (in_valid_i && sent_cnt != acc_cnt) begin
      // hold the word until it is taken
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (pixel_q.size() != 0) begin
      in_data_i  <= pixel_q.pop_front();
      in_valid_i <= 1'b1;
      sent_cnt++;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: output stall pattern switches at random among none, light, heavy and periodic
  stall_style_e stall_style = STALL_NONE;
  int           stall_left = 0;
  int           stall_tick = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_tick % 8) < 3);
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("word %0d %s got %02h expected %02h", acc_cnt, name, got, exp));
    end
  endtask

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    out_word_t exp;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               rgba_expect_q.size());
      $display("tb failed");
      $finish;
    end else begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        rgba_expect_q.push_back(render_pixel(in_data_i));
        mode_hits[mode_q]++;
        acc_cnt++;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (rgba_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output word %08h", out_data_o));
        end else begin
          exp = rgba_expect_q.pop_front();
          check_field("red", out_data_o.out_red, exp.out_red);
          check_field("green", out_data_o.out_green, exp.out_green);
          check_field("blue", out_data_o.out_blue, exp.out_blue);
          check_field("alpha", out_data_o.out_alpha, exp.out_alpha);
        end
      end
    end
  end

  initial begin
    in_word_t   corner[5];
    logic [2:0] mode_code;
    logic [7:0] col[4];
    int         pick;

    corner[0] = '0;
    corner[1] = '1;
    // farthest pair: distance saturates and the blend ratio exceeds one
    corner[2] = {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    corner[3] = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    corner[4] = {8'h01, 8'h80, 8'h7F, 8'h00, 8'h80, 8'h7F, 8'h5A};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset colors first, then each mode with a fixed color
    settings_cnt++;
    for (int i = 0; i < 5; i++) pixel_q.push_back(corner[i]);
    wait_drained();
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: set_config({5'b0, MODE_MOVEMENT}, 8'hFF, 8'h80, 8'h01, 8'h00);
        1: set_config({5'b0, MODE_FLAT_INTENSITY}, 8'h00, 8'hFF, 8'h00, 8'h11);
        2: begin
          // wide mode word keeps its low bits; unused indexes are dropped
          set_config({5'b11111, MODE_MOVEMENT_INTENSITY}, 8'hFF, 8'hFF, 8'hFF, 8'h00);
          for (int idx = CFG_UNUSED_FIRST; idx <= CFG_UNUSED_LAST; idx++) begin
            write_reg(3'(idx), 8'hFF);
          end
        end
        default: set_config({5'b0, MODE_DIFF_ONLY}, 8'h12, 8'h34, 8'h56, 8'h78);
      endcase
      for (int i = 0; i < 5; i++) pixel_q.push_back(corner[i]);
      wait_drained();
    end

    // random phases: every mode code incl. unused ones, then weighted toward blending
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 8) begin
        mode_code = 3'(ph);
      end else begin
        pick = $urandom_range(0, 6);
        mode_code = (pick > 4) ? MODE_MOVEMENT_INTENSITY : 3'(pick);
      end
      for (int c = 0; c < 4; c++) begin
        pick = $urandom_range(0, 3);
        col[c] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        if (ph == RANDOM_PHASES - 2) col[c] = 8'h00;
        if (ph == RANDOM_PHASES - 1) col[c] = 8'hFF;
      end
      set_config({5'($urandom_range(0, 31)), mode_code}, col[0], col[1], col[2], col[3]);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(3'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)), 8'($urandom));
      end
      for (int i = 0; i < PIXELS_PER_PHASE; i++) pixel_q.push_back(rand_pixel());
      wait_drained();
    end

    // catch stray words past the pipeline depth
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("rendered %0d pixels under %0d register settings, %0d mismatches",
             acc_cnt, settings_cnt, err_cnt);
    $display("pixels per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
